>>> sv/ylb_pkg.sv
`default_nettype none

package ylb_pkg;

	// Depth limits of the sample format.
	localparam int unsigned MAX_DEPTH = 16;
	localparam int unsigned MIN_DEPTH = 8;

	localparam int unsigned NPLANE = 3;           // Y, Cb, Cr
	localparam int unsigned SW     = 16;          // sample width
	localparam int unsigned DW     = SW + 2;      // signed luma difference (hard light)
	localparam int unsigned MAGW   = SW + 1;      // magnitude of a difference
	localparam int unsigned NUMW   = SW + MAGW;   // dividend of a division by max
	localparam int unsigned QW     = NUMW - MIN_DEPTH + 1; // quotient width
	localparam int unsigned VW     = QW + 2;      // signed blended value
	localparam int unsigned SPW    = 14;          // fade span, up to 2^(MAX_DEPTH-3)
	localparam int unsigned ACCW   = VW + SPW + 1; // fade accumulator
	localparam int unsigned DEPW   = 5;           // bit_depth register width
	localparam int unsigned SHW    = 4;           // shift amounts up to MAX_DEPTH-1

	localparam int unsigned IN_W   = 3 * NPLANE * SW;
	localparam int unsigned OUT_W  = NPLANE * SW;

	typedef enum logic [1:0] {
		REG_HARD_LIGHT = 2'd0,
		REG_BIT_DEPTH  = 2'd1,
		REG_OPACITY    = 2'd2,
		REG_USE_MASK   = 2'd3
	} reg_idx_t;

	// Settings derived from the configuration registers.
	typedef struct packed {
		logic            hard_light;
		logic            use_mask;
		logic [DEPW-1:0] depth;    // clamped sample depth d
		logic [SHW-1:0]  hsh;      // d - 1
		logic [SHW-1:0]  sh;       // d - 3
		logic [SW-1:0]   mx;       // 2^d - 1
		logic [SW-1:0]   half;     // 2^(d-1)
		logic [SW-1:0]   rnd;      // max / 2
		logic [SPW-1:0]  span;     // 2^(d-3)
		logic [SW-1:0]   opacity;  // saturated to max
	} cfg_t;

	// Partial state of a division by 2^d - 1.
	typedef struct packed {
		logic [NUMW-1:0] t;
		logic [QW-1:0]   q;
	} div_t;

	// One folding step: t = a*2^d + b = a*(2^d - 1) + (a + b).
	function automatic div_t div_fold(input div_t x, input logic [DEPW-1:0] d,
			input logic [SW-1:0] mx);
		div_t            r;
		logic [NUMW-1:0] a;
		a   = x.t >> d;
		r.t = a + (x.t & NUMW'(mx));
		r.q = x.q + QW'(a);
		return r;
	endfunction

	// After four folds the remainder is below twice the divisor.
	function automatic logic [QW-1:0] div_finish(input div_t x, input logic [SW-1:0] mx);
		return (x.t >= NUMW'(mx)) ? x.q + QW'(1) : x.q;
	endfunction

endpackage

`default_nettype wire

>>> sv/yuv_light_blend_pixel_top.sv
`default_nettype none

// Soft-light / hard-light blend of one YUV pixel per item.
// The input stream (s_t*) carries a base pixel, an overlay pixel and one mask
// weight per plane; the output stream (m_t*) carries the blended Y, Cb, Cr.
// An item is moved on either stream at a rising edge where tvalid and tready
// are both high. The APB port sets hard_light (0x0), bit_depth (0x4),
// opacity_level (0x8) and use_mask (0xC); write it only while no item is in
// flight.
// Throughput is one item per clock while the receiver keeps m_tready high. An
// item passes through nine register stages: a product stage, two stages of
// folding division by 2^d-1 for the mask weight, a weighting multiply, two
// more division stages, the luma clamp, the chroma fade multiply and the
// output register.
// Each stage holds its own valid bit and moves whenever it is empty or its
// successor moves, so a stalled receiver only freezes the stages that are
// full; bubbles are squeezed out and s_tready stays high until all nine
// stages hold items. Nothing is dropped or repeated during a stall.
// Reset clears all valid bits and loads the register defaults: soft light,
// 8-bit samples, opacity 255 and no mask.

module yuv_light_blend_pixel_top
	import ylb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// APB configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// Pixel input stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// s_tdata fields from bit 0: base_luma, base_cb, base_cr, over_luma,
	// over_cb, over_cr, mask_luma, mask_cb, mask_cr (16 bits each)
	input  wire logic [IN_W-1:0]   s_tdata,
	// Blended pixel output stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// m_tdata fields from bit 0: out_luma, out_cb, out_cr (16 bits each)
	output logic [OUT_W-1:0]       m_tdata
);

	// Configuration registers, as written.
	logic            hard_light_q;
	logic [DEPW-1:0] bit_depth_q;
	logic [SW-1:0]   opacity_q;
	logic            use_mask_q;

	logic     wr_en;
	reg_idx_t wr_idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_light_q <= 1'b0;
			bit_depth_q  <= DEPW'(MIN_DEPTH);
			opacity_q    <= SW'(255);
			use_mask_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_HARD_LIGHT: hard_light_q <= pwdata[0];
				REG_BIT_DEPTH:  bit_depth_q  <= pwdata[DEPW-1:0];
				REG_OPACITY:    opacity_q    <= pwdata[SW-1:0];
				REG_USE_MASK:   use_mask_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_HARD_LIGHT: prdata = {31'b0, hard_light_q};
			REG_BIT_DEPTH:  prdata = {{(32-DEPW){1'b0}}, bit_depth_q};
			REG_OPACITY:    prdata = {{(32-SW){1'b0}}, opacity_q};
			REG_USE_MASK:   prdata = {31'b0, use_mask_q};
			default:        prdata = '0;
		endcase
	end

	// Derived settings. They follow the registers directly, so an item taken
	// right after a write already sees the new values.
	cfg_t            cfg;
	logic [DEPW-1:0] depth_c;
	logic [SW:0]     pow_c;

	always_comb begin
		if (bit_depth_q < DEPW'(MIN_DEPTH)) begin
			depth_c = DEPW'(MIN_DEPTH);
		end else if (bit_depth_q > DEPW'(MAX_DEPTH)) begin
			depth_c = DEPW'(MAX_DEPTH);
		end else begin
			depth_c = bit_depth_q;
		end
		pow_c          = (SW+1)'(1) << depth_c;
		cfg.hard_light = hard_light_q;
		cfg.use_mask   = use_mask_q;
		cfg.depth      = depth_c;
		cfg.hsh        = SHW'(depth_c - DEPW'(1));
		cfg.sh         = SHW'(depth_c - DEPW'(3));
		cfg.mx         = SW'(pow_c - (SW+1)'(1));
		cfg.half       = pow_c[SW:1];
		cfg.rnd        = cfg.mx >> 1;
		cfg.span       = SPW'(1) << cfg.sh;
		// Opacity saturates at the maximum sample value.
		cfg.opacity    = (opacity_q > cfg.mx) ? cfg.mx : opacity_q;
	end

	ylb_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

>>> sv/ylb_pipe.sv
`default_nettype none

module ylb_pipe
	import ylb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [IN_W-1:0]  in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [OUT_W-1:0]      out_data
);

	// Stage enables: a stage moves when it is empty or its successor moves.
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8, adv_out;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, out_valid_q;

	assign adv_out = !out_valid_q || out_ready;
	assign adv_s8  = !v_s8 || adv_out;
	assign adv_s7  = !v_s7 || adv_s8;
	assign adv_s6  = !v_s6 || adv_s7;
	assign adv_s5  = !v_s5 || adv_s6;
	assign adv_s4  = !v_s4 || adv_s5;
	assign adv_s3  = !v_s3 || adv_s4;
	assign adv_s2  = !v_s2 || adv_s3;
	assign adv_s1  = !v_s1 || adv_s2;
	assign in_ready  = adv_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
			if (adv_s7) v_s7 <= v_s6;
			if (adv_s8) v_s8 <= v_s7;
			if (adv_out) out_valid_q <= v_s8;
		end
	end

	// Stage 1: blend differences and mask-times-opacity products.
	logic [SW-1:0]          base_c [NPLANE];
	logic [SW-1:0]          over_c [NPLANE];
	logic [SW-1:0]          mask_c [NPLANE];
	logic signed [DW-1:0]   dif_c  [NPLANE];
	logic [SW-1:0]          base_s1 [NPLANE];
	logic                   sgn_s1  [NPLANE];
	logic [MAGW-1:0]        mag_s1  [NPLANE];
	logic [2*SW-1:0]        pm_s1   [NPLANE];

	always_comb begin
		for (int p = 0; p < NPLANE; p++) begin
			base_c[p] = in_data[p*SW +: SW];
			over_c[p] = in_data[(NPLANE+p)*SW +: SW];
			mask_c[p] = in_data[(2*NPLANE+p)*SW +: SW];
			if (p == 0 && cfg.hard_light) begin
				dif_c[p] = $signed({1'b0, over_c[p], 1'b0}) - $signed({1'b0, cfg.half, 1'b0});
			end else begin
				dif_c[p] = $signed({2'b0, over_c[p]}) - $signed({2'b0, cfg.half});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			for (int p = 0; p < NPLANE; p++) begin
				base_s1[p] <= base_c[p];
				sgn_s1[p]  <= dif_c[p][DW-1];
				mag_s1[p]  <= dif_c[p][DW-1] ? MAGW'(-dif_c[p]) : MAGW'(dif_c[p]);
				pm_s1[p]   <= (2*SW)'(mask_c[p]) * (2*SW)'(cfg.opacity) + (2*SW)'(cfg.rnd);
			end
		end
	end

	// Stages 2 and 3: mask weight, (mask * opacity + max/2) / max; the opacity without mask.
	div_t            wd_s2   [NPLANE];
	logic [SW-1:0]   base_s2 [NPLANE];
	logic            sgn_s2  [NPLANE];
	logic [MAGW-1:0] mag_s2  [NPLANE];

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			for (int p = 0; p < NPLANE; p++) begin
				wd_s2[p]   <= div_fold(div_fold(div_t'{t: NUMW'(pm_s1[p]), q: '0},
					cfg.depth, cfg.mx), cfg.depth, cfg.mx);
				base_s2[p] <= base_s1[p];
				sgn_s2[p]  <= sgn_s1[p];
				mag_s2[p]  <= mag_s1[p];
			end
		end
	end

	logic [QW-1:0]   wq_c    [NPLANE];
	logic [SW-1:0]   w_s3    [NPLANE];
	logic [SW-1:0]   base_s3 [NPLANE];
	logic            sgn_s3  [NPLANE];
	logic [MAGW-1:0] mag_s3  [NPLANE];

	always_comb begin
		for (int p = 0; p < NPLANE; p++) begin
			wq_c[p] = div_finish(div_fold(div_fold(wd_s2[p], cfg.depth, cfg.mx),
				cfg.depth, cfg.mx), cfg.mx);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			for (int p = 0; p < NPLANE; p++) begin
				w_s3[p]    <= cfg.use_mask ? wq_c[p][SW-1:0] : cfg.opacity;
				base_s3[p] <= base_s2[p];
				sgn_s3[p]  <= sgn_s2[p];
				mag_s3[p]  <= mag_s2[p];
			end
		end
	end

	// Stage 4: weighted magnitude plus rounding term.
	logic [NUMW-1:0] x_s4    [NPLANE];
	logic [SW-1:0]   base_s4 [NPLANE];
	logic            sgn_s4  [NPLANE];

	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			for (int p = 0; p < NPLANE; p++) begin
				x_s4[p]    <= NUMW'(w_s3[p]) * NUMW'(mag_s3[p]) + NUMW'(cfg.rnd);
				base_s4[p] <= base_s3[p];
				sgn_s4[p]  <= sgn_s3[p];
			end
		end
	end

	// Stages 5 and 6: divide by max, restore the sign, add the base.
	div_t          xd_s5   [NPLANE];
	logic [SW-1:0] base_s5 [NPLANE];
	logic          sgn_s5  [NPLANE];

	always_ff @(posedge clk) begin
		if (adv_s5 && v_s4) begin
			for (int p = 0; p < NPLANE; p++) begin
				xd_s5[p]   <= div_fold(div_fold(div_t'{t: x_s4[p], q: '0},
					cfg.depth, cfg.mx), cfg.depth, cfg.mx);
				base_s5[p] <= base_s4[p];
				sgn_s5[p]  <= sgn_s4[p];
			end
		end
	end

	logic [QW-1:0]        sq_c   [NPLANE];
	logic signed [VW-1:0] sqs_c  [NPLANE];
	logic signed [VW-1:0] val_s6 [NPLANE];

	always_comb begin
		for (int p = 0; p < NPLANE; p++) begin
			sq_c[p]  = div_finish(div_fold(div_fold(xd_s5[p], cfg.depth, cfg.mx),
				cfg.depth, cfg.mx), cfg.mx);
			sqs_c[p] = $signed({2'b0, sq_c[p]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s6 && v_s5) begin
			for (int p = 0; p < NPLANE; p++) begin
				val_s6[p] <= $signed({{(VW-SW){1'b0}}, base_s5[p]})
					+ (sgn_s5[p] ? -sqs_c[p] : sqs_c[p]);
			end
		end
	end

	// Stage 7: luma clamp and chroma fade coefficients.
	logic signed [VW-1:0] y_c, mx_c, span_c, mo_c, mu_c;
	logic                 bright_c, dark_c;
	logic [SPW-1:0]       mov_c, mun_c;
	logic [SW-1:0]        yo_s7;
	logic                 fade_s7;
	logic [SPW-1:0]       cu_s7, ch_s7;
	logic signed [VW-1:0] uv_s7 [NPLANE-1];

	always_comb begin
		y_c      = val_s6[0];
		mx_c     = $signed({{(VW-SW){1'b0}}, cfg.mx});
		span_c   = $signed({{(VW-SPW){1'b0}}, cfg.span});
		bright_c = y_c > mx_c;
		dark_c   = y_c[VW-1];
		mo_c     = mx_c + VW'(1) + span_c - y_c;
		mu_c     = -y_c;
		mov_c    = mo_c[VW-1] ? '0 : mo_c[SPW-1:0];
		mun_c    = (mu_c > span_c) ? cfg.span : mu_c[SPW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv_s7 && v_s6) begin
			fade_s7 <= bright_c || dark_c;
			if (bright_c) begin
				yo_s7 <= cfg.mx;
				cu_s7 <= mov_c;
				ch_s7 <= cfg.span - mov_c;
			end else if (dark_c) begin
				yo_s7 <= '0;
				cu_s7 <= cfg.span - mun_c;
				ch_s7 <= mun_c;
			end else begin
				yo_s7 <= y_c[SW-1:0];
				cu_s7 <= '0;
				ch_s7 <= '0;
			end
			for (int p = 0; p < NPLANE - 1; p++) begin
				uv_s7[p] <= val_s6[p+1];
			end
		end
	end

	// Stage 8: chroma * c + half * (span - c) while fading; otherwise chroma as is.
	logic signed [ACCW-1:0] pr_c  [NPLANE-1];
	logic [ACCW-1:0]        hv_c;
	logic [SW-1:0]          yo_s8;
	logic                   fade_s8;
	logic signed [ACCW-1:0] acc_s8 [NPLANE-1];

	always_comb begin
		hv_c = ACCW'(ch_s7) << cfg.hsh;
		for (int p = 0; p < NPLANE - 1; p++) begin
			pr_c[p] = $signed(uv_s7[p]) * $signed({1'b0, cu_s7});
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s8 && v_s7) begin
			yo_s8   <= yo_s7;
			fade_s8 <= fade_s7;
			for (int p = 0; p < NPLANE - 1; p++) begin
				acc_s8[p] <= fade_s7 ? pr_c[p] + $signed(hv_c) : ACCW'(uv_s7[p]);
			end
		end
	end

	// Output register: floor shift of faded chroma and clamp to 0..max.
	logic signed [ACCW-1:0] f_c [NPLANE-1];
	logic [SW-1:0]          res_q [NPLANE];

	always_comb begin
		for (int p = 0; p < NPLANE - 1; p++) begin
			f_c[p] = fade_s8 ? (acc_s8[p] >>> cfg.sh) : acc_s8[p];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s8) begin
			res_q[0] <= yo_s8;
			for (int p = 0; p < NPLANE - 1; p++) begin
				if (f_c[p][ACCW-1]) begin
					res_q[p+1] <= '0;
				end else if (f_c[p] > $signed({{(ACCW-SW){1'b0}}, cfg.mx})) begin
					res_q[p+1] <= cfg.mx;
				end else begin
					res_q[p+1] <= f_c[p][SW-1:0];
				end
			end
		end
	end

	always_comb begin
		for (int p = 0; p < NPLANE; p++) begin
			out_data[p*SW +: SW] = res_q[p];
		end
	end

endmodule

`default_nettype wire

>>> sim/ylb_blend_checker.sv
`timescale 1ns / 1ps

// Watches the APB port and both pixel streams of the light blend block. It keeps
// its own copy of the registers and works out the blended pixel for every
// accepted input item. Each accepted output item is compared with the oldest
// outstanding blended pixel.
module ylb_blend_checker
	import ylb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic             pready,
	input  wire logic [3:0]       paddr,
	input  wire logic [31:0]      pwdata,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [OUT_W-1:0] m_tdata,
	output int                    errors,
	output int                    pending
);

	logic        hard_q;
	logic [4:0]  depth_q;
	logic [15:0] opac_q;
	logic        mask_q;

	logic [OUT_W-1:0] blended_q [$];
	string            plane_tag [NPLANE] = '{"out_luma", "out_cb", "out_cr"};

	// Rounded division of w * diff by max, symmetric around zero.
	function automatic longint weigh_diff(input longint w, input longint diff,
			input longint mx);
		if (diff >= 0)
			return (w * diff + mx / 2) / mx;
		return -((w * (-diff) + mx / 2) / mx);
	endfunction

	function automatic logic [OUT_W-1:0] blend_pixel(input logic [IN_W-1:0] px);
		int unsigned dep;
		int unsigned sh;
		longint      mx, half, span, opac, m;
		longint      by, bu, bv, oy, ou, ov;
		longint      y, u, v, wy, wu, wv;
		dep = depth_q;
		if (dep < MIN_DEPTH) dep = MIN_DEPTH;
		if (dep > MAX_DEPTH) dep = MAX_DEPTH;
		mx   = (longint'(1) << dep) - 1;
		half = longint'(1) << (dep - 1);
		sh   = dep - 3;
		span = longint'(1) << sh;
		opac = longint'(opac_q);
		if (opac > mx) opac = mx;

		by = longint'(px[0*SW +: SW]);
		bu = longint'(px[1*SW +: SW]);
		bv = longint'(px[2*SW +: SW]);
		oy = longint'(px[3*SW +: SW]);
		ou = longint'(px[4*SW +: SW]);
		ov = longint'(px[5*SW +: SW]);

		y = hard_q ? by + 2 * oy - 2 * half : by + oy - half;
		u = bu + ou - half;
		v = bv + ov - half;

		wy = opac;
		wu = opac;
		wv = opac;
		if (mask_q) begin
			wy = (longint'(px[6*SW +: SW]) * opac + mx / 2) / mx;
			wu = (longint'(px[7*SW +: SW]) * opac + mx / 2) / mx;
			wv = (longint'(px[8*SW +: SW]) * opac + mx / 2) / mx;
		end
		y = by + weigh_diff(wy, y - by, mx);
		u = bu + weigh_diff(wu, u - bu, mx);
		v = bv + weigh_diff(wv, v - bv, mx);

		// Luma out of range drags chroma toward grey in proportion to the overshoot.
		if (y > mx) begin
			m = mx + 1 + span - y;
			if (m < 0) m = 0;
			u = (u * m + half * (span - m)) >>> sh;
			v = (v * m + half * (span - m)) >>> sh;
			y = mx;
		end else if (y < 0) begin
			m = -y;
			if (m > span) m = span;
			u = (u * (span - m) + half * m) >>> sh;
			v = (v * (span - m) + half * m) >>> sh;
			y = 0;
		end
		if (u < 0) u = 0;
		if (u > mx) u = mx;
		if (v < 0) v = 0;
		if (v > mx) v = mx;
		return {v[SW-1:0], u[SW-1:0], y[SW-1:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [OUT_W-1:0] want;
		if (!arst_n) begin
			hard_q  = 1'b0;
			depth_q = 5'd8;
			opac_q  = 16'd255;
			mask_q  = 1'b0;
			blended_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_HARD_LIGHT: hard_q  = pwdata[0];
					REG_BIT_DEPTH:  depth_q = pwdata[4:0];
					REG_OPACITY:    opac_q  = pwdata[15:0];
					REG_USE_MASK:   mask_q  = pwdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				blended_q.push_back(blend_pixel(s_tdata));
			if (m_tvalid && m_tready) begin
				if (blended_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none, got 0x%012h", $time,
						m_tdata);
				end else begin
					want = blended_q.pop_front();
					for (int k = 0; k < NPLANE; k++) begin
						if (m_tdata[k*SW +: SW] !== want[k*SW +: SW]) begin
							errors++;
							$display("%0t: %s expected 0x%04h, got 0x%04h", $time,
								plane_tag[k], want[k*SW +: SW], m_tdata[k*SW +: SW]);
						end
					end
				end
			end
			pending <= blended_q.size();
		end
	end

endmodule

>>> sim/yuv_light_blend_pixel_top_test.sv
`timescale 1ns / 1ps

// Testbench for the YUV light blend block. This module only makes stimulus:
// register settings over the APB port, pixel items on the input stream, and a
// ready pattern on the output stream. The checker beside the block predicts
// and compares every blended pixel and reports how many mismatches it saw.
module yuv_light_blend_pixel_top_test;
	import ylb_pkg::*;

	// The block has nine register stages; the settle wait below is derived from
	// that depth and runs once nothing is outstanding.
	localparam int PIPE_STAGES    = 9;
	localparam int SETTLE_CYCLES  = PIPE_STAGES + 4;
	// Long receiver hold-off; far longer than the pipeline, so the block fills
	// up and drops s_tready while the sender keeps offering items.
	localparam int HOLD_CYCLES    = 200;
	// Longest correct quiet stretch is the hold-off above; the limit is many
	// times that.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 14;
	localparam int PHASE_ITEMS    = 90;
	localparam int PRESSURE_PHASE = 8;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [3:0]        paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic              s_tvalid = 1'b0;
	// s_tdata fields from bit 0: base_luma, base_cb, base_cr, over_luma,
	// over_cb, over_cr, mask_luma, mask_cb, mask_cr (16 bits each)
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tready = 1'b0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tready;
	logic              m_tvalid;
	// m_tdata fields from bit 0: out_luma, out_cb, out_cr (16 bits each)
	logic [OUT_W-1:0]  m_tdata;

	int          errors;
	int          pending;
	int          quiet_cycles = 0;
	// Random idling on both streams is allowed while this is set.
	bit          idle_on      = 1'b1;
	// Set by the stimulus to ask the receiver for one long hold-off.
	bit          hold_req     = 1'b0;
	// Largest in-range sample at the depth currently programmed.
	int unsigned cur_max      = 255;

	yuv_light_blend_pixel_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ylb_blend_checker blend_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The watchdog ends the run when nothing at all is accepted for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Receiver: mostly ready, with random stall bursts while idling is on, and a
	// single long hold-off when the stimulus asks for it. Each pass of the loop
	// makes its assignments at distinct clock edges.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// APB write: a setup phase, then an access phase. The register takes the value
	// at the end of the access phase, since pready is always high. The bus then rests
	// idle, so back-to-back writes drive each signal once per edge.
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one pixel item and returns at the edge where it was accepted. The
	// valid stays high so the next item can follow back to back.
	task automatic push_pixel(input logic [IN_W-1:0] px);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops offering and waits until every outstanding blended pixel has come
	// out, then lets the pipeline run empty for the settle wait.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reprograms all four registers once the block is idle.
	task automatic program_blend(input bit hard, input logic [4:0] depth,
			input logic [15:0] opac, input bit mask);
		int unsigned dep;
		wait_drained();
		apb_write(REG_HARD_LIGHT, {31'd0, hard});
		apb_write(REG_BIT_DEPTH, {27'd0, depth});
		apb_write(REG_OPACITY, {16'd0, opac});
		apb_write(REG_USE_MASK, {31'd0, mask});
		dep = depth;
		if (dep < MIN_DEPTH) dep = MIN_DEPTH;
		if (dep > MAX_DEPTH) dep = MAX_DEPTH;
		cur_max = (1 << dep) - 1;
	endtask

	function automatic logic [IN_W-1:0] pack_pixel(input logic [15:0] by, bu, bv,
			oy, ou, ov, my, mu, mv);
		return {mv, mu, my, ov, ou, oy, bv, bu, by};
	endfunction

	// Samples lean on the edges of the current range and on values around the
	// grey level, where the luma sum crosses zero or max; a few lie above max.
	function automatic logic [15:0] rand_sample();
		int unsigned spread;
		spread = cur_max / 8;
		case ($urandom_range(0, 19)) inside
			0, 1:    return 16'd0;
			2, 3:    return 16'(cur_max);
			4:       return 16'($urandom);
			5:       return 16'hFFFF;
			6, 7:    return 16'(cur_max / 2 - spread / 2 + $urandom_range(0, spread));
			default: return 16'($urandom_range(0, cur_max));
		endcase
	endfunction

	function automatic logic [IN_W-1:0] rand_pixel();
		logic [IN_W-1:0] px;
		for (int k = 0; k < 3 * NPLANE; k++)
			px[k*SW +: SW] = rand_sample();
		return px;
	endfunction

	initial begin : stimulus
		bit          hard;
		bit          mask;
		logic [4:0]  depth;
		logic [15:0] opac;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset settings: soft light, 8 bits, opacity 255,
		// no mask. They cover both clamps, the grey identity and samples above max.
		push_pixel(pack_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0));
		push_pixel(pack_pixel(255, 255, 255, 255, 255, 255, 255, 255, 255));
		push_pixel(pack_pixel(128, 128, 128, 128, 128, 128, 0, 0, 0));
		push_pixel(pack_pixel('1, '1, '1, '1, '1, '1, '1, '1, '1));
		push_pixel(pack_pixel(0, 255, 0, 0, 255, 0, 17, 99, 3));
		push_pixel(pack_pixel(255, 0, 255, 255, 0, 255, 0, 0, 0));
		// Slight overshoot and slight undershoot, where the chroma fade is partial.
		push_pixel(pack_pixel(200, 30, 220, 190, 40, 230, 0, 0, 0));
		push_pixel(pack_pixel(50, 30, 220, 70, 40, 230, 0, 0, 0));
		push_pixel(pack_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
			16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));

		// Directed items in hard light at 16 bits with full opacity and masks.
		program_blend(1'b1, 5'd16, 16'hFFFF, 1'b1);
		push_pixel(pack_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0));
		push_pixel(pack_pixel('1, '1, '1, '1, '1, '1, '1, '1, '1));
		push_pixel(pack_pixel(16'h1234, 16'h9ABC, 16'h0F0F, '1, '1, '1, 0, 0, 0));
		push_pixel(pack_pixel('1, 0, '1, '1, 0, '1, '1, '1, '1));
		push_pixel(pack_pixel(0, '1, 0, 0, '1, 0, '1, '1, '1));
		push_pixel(pack_pixel(16'h1234, 16'h4321, 16'hC000, 16'hFEDC, 16'h0123,
			16'h8000, 16'h8000, 16'h8000, 16'h8000));
		push_pixel(pack_pixel(16'h8000, 16'h8000, 16'h8000, 16'h4000, 16'h8000,
			16'h8000, 16'hFFFF, 16'h7FFF, 16'h0001));
		push_pixel(pack_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));

		// Random phases. The first ones pin the extremes: both blend modes, the
		// smallest and largest depths, depths outside 8..16 that the block must
		// clamp, zero opacity and opacity that saturates. The rest are random.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin hard = 0; depth = 5'd8;  opac = 16'd255;   mask = 0; end
				1: begin hard = 1; depth = 5'd16; opac = 16'hFFFF;  mask = 1; end
				2: begin hard = 0; depth = 5'd16; opac = 16'd0;     mask = 1; end
				3: begin hard = 1; depth = 5'd8;  opac = 16'hFFFF;  mask = 0; end
				4: begin hard = 0; depth = 5'd0;  opac = 16'd128;   mask = 1; end
				5: begin hard = 1; depth = 5'd31; opac = 16'd40000; mask = 0; end
				6: begin hard = 0; depth = 5'd7;  opac = 16'd300;   mask = 1; end
				7: begin hard = 1; depth = 5'd17; opac = 16'd1000;  mask = 1; end
				default: begin
					hard  = 1'($urandom_range(0, 1));
					mask  = 1'($urandom_range(0, 1));
					depth = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
						: 5'($urandom_range(8, 16));
					case ($urandom_range(0, 3))
						0:       opac = 16'($urandom);
						1:       opac = 16'hFFFF;
						default: opac = 16'($urandom_range(0, (1 << depth) - 1));
					endcase
				end
			endcase
			// The last phase runs with both streams at full rate.
			idle_on = (p != PHASES - 1);
			program_blend(hard, depth, opac, mask);
			if (p == PRESSURE_PHASE)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) push_pixel(rand_pixel());
		end

		wait_drained();
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
